// ===== rtl/dfsam_pkg.sv =====
package dfsam_pkg;

  // Sizes of the graph, the pending stack and the result cap.
  localparam int MaxVertices = 16;
  localparam int StackDepth  = 256;
  localparam int MaxResults  = 16;

  // Field and counter widths.
  localparam int VtxW   = 4;
  localparam int VcW    = 5;
  localparam int CntW   = $clog2(MaxResults + 1);
  localparam int SpW    = $clog2(StackDepth + 1);
  localparam int SAddrW = $clog2(StackDepth);

  localparam logic [VcW-1:0] VertexCountReset = VcW'(16);

  // Input mode codes.
  localparam logic ModeEdge   = 1'b0;
  localparam logic ModeSearch = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_READ,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // One edge write into the adjacency matrix.
  typedef struct packed {
    logic            we;
    logic [VtxW-1:0] row;
    logic [VtxW-1:0] col;
    logic            conn;
  } edge_wr_t;

  // Write and read requests to the pending stack memory.
  typedef struct packed {
    logic              we;
    logic [SAddrW-1:0] waddr;
    logic [VtxW-1:0]   wdata;
    logic              re;
    logic [SAddrW-1:0] raddr;
  } stack_req_t;

endpackage

// ===== rtl/dfsam_stack.sv =====
module dfsam_stack (
  input  logic                       clk_i,
  input  dfsam_pkg::stack_req_t      req_i,
  output logic [dfsam_pkg::VtxW-1:0] rdata_o
);

  logic [dfsam_pkg::VtxW-1:0] mem [dfsam_pkg::StackDepth];
  logic [dfsam_pkg::VtxW-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dfsam_adj.sv =====
module dfsam_adj (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dfsam_pkg::edge_wr_t               edge_i,
  input  logic [dfsam_pkg::VtxW-1:0]        rd_row_i,
  output logic [dfsam_pkg::MaxVertices-1:0] row_o
);

  logic [dfsam_pkg::MaxVertices-1:0] adj_q [dfsam_pkg::MaxVertices];
  logic                              in_range;

  // Edges outside the matrix are dropped.
  assign in_range = ((dfsam_pkg::VtxW + 1)'(edge_i.row)
                     < (dfsam_pkg::VtxW + 1)'(dfsam_pkg::MaxVertices))
                 && ((dfsam_pkg::VtxW + 1)'(edge_i.col)
                     < (dfsam_pkg::VtxW + 1)'(dfsam_pkg::MaxVertices));

  // Each edge sets or clears its bit and the mirror bit, keeping the graph undirected.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < dfsam_pkg::MaxVertices; r++) begin
        adj_q[r] <= '0;
      end
    end else if (edge_i.we && in_range) begin
      adj_q[edge_i.row][edge_i.col] <= edge_i.conn;
      adj_q[edge_i.col][edge_i.row] <= edge_i.conn;
    end
  end

  // Row of the vertex being expanded.
  assign row_o = adj_q[rd_row_i];

endmodule

// ===== rtl/dfsam_ctrl.sv =====
module dfsam_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dfsam_pkg::VcW-1:0]         cfg_vertex_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [dfsam_pkg::VtxW-1:0]        row_i,
  input  logic [dfsam_pkg::VtxW-1:0]        col_i,
  input  logic                              connected_i,
  input  logic [dfsam_pkg::VtxW-1:0]        start_vertex_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dfsam_pkg::VtxW-1:0]        vertex_o,
  output logic                              last_o,
  output logic                              error_o,
  output dfsam_pkg::edge_wr_t               edge_o,
  output logic [dfsam_pkg::VtxW-1:0]        cur_v_o,
  input  logic [dfsam_pkg::MaxVertices-1:0] adj_row_i,
  output dfsam_pkg::stack_req_t             stack_o,
  input  logic [dfsam_pkg::VtxW-1:0]        stack_rdata_i
);

  dfsam_pkg::state_e state_q, state_d;

  logic [dfsam_pkg::VcW-1:0]         vc_q, vc_d;
  logic [dfsam_pkg::MaxVertices-1:0] visited_q, visited_d;
  logic [dfsam_pkg::SpW-1:0]         sp_q, sp_d;
  logic [dfsam_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [dfsam_pkg::VtxW-1:0]        cur_v_q, cur_v_d;
  logic [dfsam_pkg::VtxW-1:0]        idx_q, idx_d;
  logic                              pend_valid_q, pend_valid_d;
  logic [dfsam_pkg::VtxW-1:0]        pend_v_q, pend_v_d;
  logic                              out_valid_q, out_valid_d;
  logic [dfsam_pkg::VtxW-1:0]        out_vertex_q, out_vertex_d;
  logic                              out_last_q, out_last_d;
  logic                              out_error_q, out_error_d;

  logic [dfsam_pkg::VcW-1:0] n_eff;
  logic                      out_free;
  logic                      in_acc;
  logic                      start_bad;
  logic                      sp_empty;
  logic                      sp_full;
  logic                      popped_seen;
  logic                      cap_hit;
  logic                      can_emit;
  logic                      scan_last;
  logic                      push_hit;

  // Vertex count above the matrix size acts as the matrix size.
  assign n_eff = (vc_q > dfsam_pkg::VcW'(dfsam_pkg::MaxVertices))
               ? dfsam_pkg::VcW'(dfsam_pkg::MaxVertices) : vc_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == dfsam_pkg::ST_IDLE) && out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign start_bad   = dfsam_pkg::VcW'(start_vertex_i) >= n_eff;
  assign sp_empty    = (sp_q == '0);
  assign sp_full     = (sp_q >= dfsam_pkg::SpW'(dfsam_pkg::StackDepth));
  assign popped_seen = visited_q[stack_rdata_i];
  assign cap_hit     = (cnt_q == dfsam_pkg::CntW'(dfsam_pkg::MaxResults));
  assign can_emit    = !pend_valid_q || out_free;
  assign scan_last   = (dfsam_pkg::VcW'(idx_q) + dfsam_pkg::VcW'(1)) >= n_eff;
  assign push_hit    = adj_row_i[idx_q] && !visited_q[idx_q];

  assign cfg_ready_o = 1'b1;
  assign cur_v_o     = cur_v_q;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfsam_pkg::ST_IDLE: begin
        if (in_acc && (mode_i == dfsam_pkg::ModeSearch) && !start_bad) begin
          state_d = dfsam_pkg::ST_POP;
        end
      end
      dfsam_pkg::ST_POP: begin
        state_d = sp_empty ? dfsam_pkg::ST_FLUSH : dfsam_pkg::ST_READ;
      end
      dfsam_pkg::ST_READ: begin
        if (popped_seen) begin
          state_d = dfsam_pkg::ST_POP;
        end else if (cap_hit) begin
          state_d = dfsam_pkg::ST_FLUSH;
        end else if (can_emit) begin
          state_d = dfsam_pkg::ST_SCAN;
        end
      end
      dfsam_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = dfsam_pkg::ST_POP;
        end
      end
      dfsam_pkg::ST_FLUSH: begin
        if (can_emit) begin
          state_d = dfsam_pkg::ST_IDLE;
        end
      end
      default: state_d = dfsam_pkg::ST_IDLE;
    endcase
  end

  // Datapath, stack requests and edge writes for each state.
  always_comb begin
    vc_d         = vc_q;
    visited_d    = visited_q;
    sp_d         = sp_q;
    cnt_d        = cnt_q;
    cur_v_d      = cur_v_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_v_d     = pend_v_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    out_error_d  = out_error_q;
    edge_o       = '0;
    stack_o      = '0;

    if (cfg_valid_i) begin
      vc_d = cfg_vertex_count_i;
    end

    unique case (state_q)
      dfsam_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == dfsam_pkg::ModeEdge) begin
            edge_o.we   = 1'b1;
            edge_o.row  = row_i;
            edge_o.col  = col_i;
            edge_o.conn = connected_i;
          end else if (start_bad) begin
            out_valid_d  = 1'b1;
            out_vertex_d = '0;
            out_last_d   = 1'b1;
            out_error_d  = 1'b1;
          end else begin
            visited_d     = '0;
            stack_o.we    = 1'b1;
            stack_o.waddr = '0;
            stack_o.wdata = start_vertex_i;
            sp_d          = dfsam_pkg::SpW'(1);
            cnt_d         = '0;
            pend_valid_d  = 1'b0;
          end
        end
      end
      dfsam_pkg::ST_POP: begin
        if (!sp_empty) begin
          sp_d          = sp_q - dfsam_pkg::SpW'(1);
          stack_o.re    = 1'b1;
          stack_o.raddr = sp_d[dfsam_pkg::SAddrW-1:0];
        end
      end
      dfsam_pkg::ST_READ: begin
        // A fresh vertex pushes the previous visit out, which is then known not to be last.
        if (!popped_seen) begin
          if (cap_hit) begin
            sp_d = '0;
          end else if (can_emit) begin
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_vertex_d = pend_v_q;
              out_last_d   = 1'b0;
              out_error_d  = 1'b0;
            end
            pend_valid_d             = 1'b1;
            pend_v_d                 = stack_rdata_i;
            visited_d[stack_rdata_i] = 1'b1;
            cnt_d                    = cnt_q + dfsam_pkg::CntW'(1);
            cur_v_d                  = stack_rdata_i;
            idx_d                    = '0;
          end
        end
      end
      dfsam_pkg::ST_SCAN: begin
        // One neighbor test per cycle, ascending; pushes onto a full stack are dropped.
        if (push_hit && !sp_full) begin
          stack_o.we    = 1'b1;
          stack_o.waddr = sp_q[dfsam_pkg::SAddrW-1:0];
          stack_o.wdata = idx_q;
          sp_d          = sp_q + dfsam_pkg::SpW'(1);
        end
        idx_d = idx_q + dfsam_pkg::VtxW'(1);
      end
      dfsam_pkg::ST_FLUSH: begin
        // The held visit is the final one of the search.
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = pend_v_q;
          out_last_d   = 1'b1;
          out_error_d  = 1'b0;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dfsam_pkg::ST_IDLE;
      vc_q         <= dfsam_pkg::VertexCountReset;
      visited_q    <= '0;
      sp_q         <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      vc_q         <= vc_d;
      visited_q    <= visited_d;
      sp_q         <= sp_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_v_q      <= cur_v_d;
    idx_q        <= idx_d;
    pend_v_q     <= pend_v_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
    out_error_q  <= out_error_d;
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign last_o      = out_last_q;
  assign error_o     = out_error_q;

`ifndef SYNTHESIS
  // The stack pointer never passes the stack depth.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= dfsam_pkg::SpW'(dfsam_pkg::StackDepth))
    else $error("stack pointer beyond stack depth");

  // No search emits more visits than the cap.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dfsam_pkg::CntW'(dfsam_pkg::MaxResults))
    else $error("visit count beyond cap");

  // The vertex whose row is scanned is already marked visited.
  a_scan_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfsam_pkg::ST_SCAN) |-> visited_q[cur_v_q])
    else $error("scanning an unmarked vertex");

  // A search never returns to idle with a visit still held back.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfsam_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("idle with a held visit");

  // An error result is only produced from idle.
  a_err_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_error_q && !$past(out_valid_q))
      |-> $past(state_q == dfsam_pkg::ST_IDLE))
    else $error("error result outside idle");
`endif

endmodule

// ===== rtl/depth_first_search_adjacency_matrix_top.sv =====
// Channel    Handshake                 Payload
// cfg        cfg_valid_i/cfg_ready_o   cfg_vertex_count_i
// in         in_valid_i/in_ready_o     mode_i, row_i, col_i, connected_i, start_vertex_i
// out        out_valid_o/out_ready_i   vertex_o, last_o, error_o
//
// An edge transaction writes the matrix when it is taken and gives no result.
// A search pops a vertex from the stack, takes it from the registered stack read, and scans
// the row of each newly visited vertex with the single neighbor compare step over the
// vertices in use (at most 16); when the stack is empty it flushes the final visit.
// The final visit is held back one visit so that it can carry last; a stalled output
// stalls the search. Reset is asynchronous, active low, and clears all control state;
// the stack memory needs no clearing.
module depth_first_search_adjacency_matrix_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dfsam_pkg::VcW-1:0]         cfg_vertex_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [dfsam_pkg::VtxW-1:0]        row_i,
  input  logic [dfsam_pkg::VtxW-1:0]        col_i,
  input  logic                              connected_i,
  input  logic [dfsam_pkg::VtxW-1:0]        start_vertex_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dfsam_pkg::VtxW-1:0]        vertex_o,
  output logic                              last_o,
  output logic                              error_o
);

  dfsam_pkg::edge_wr_t               edge_wr;
  dfsam_pkg::stack_req_t             stack_req;
  logic [dfsam_pkg::VtxW-1:0]        cur_v;
  logic [dfsam_pkg::MaxVertices-1:0] adj_row;
  logic [dfsam_pkg::VtxW-1:0]        stack_rdata;

  // Adjacency matrix.
  dfsam_adj u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_wr),
    .rd_row_i (cur_v),
    .row_o    (adj_row)
  );

  // Pending vertex stack.
  dfsam_stack u_stack (
    .clk_i   (clk_i),
    .req_i   (stack_req),
    .rdata_o (stack_rdata)
  );

  // Search sequencer.
  dfsam_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .row_i              (row_i),
    .col_i              (col_i),
    .connected_i        (connected_i),
    .start_vertex_i     (start_vertex_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .vertex_o           (vertex_o),
    .last_o             (last_o),
    .error_o            (error_o),
    .edge_o             (edge_wr),
    .cur_v_o            (cur_v),
    .adj_row_i          (adj_row),
    .stack_o            (stack_req),
    .stack_rdata_i      (stack_rdata)
  );

endmodule

// ===== verif/depth_first_search_adjacency_matrix_top_tb.sv =====
`timescale 1ns / 1ps

module depth_first_search_adjacency_matrix_top_tb;

  localparam int SettleCycles = 600;
  localparam int LongHold     = 400;
  localparam int DrainLimit   = 200000;
  localparam int PhaseItems   = 21;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [dfsam_pkg::VcW-1:0]  cfg_vertex_count_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       mode_i;
  logic [dfsam_pkg::VtxW-1:0] row_i;
  logic [dfsam_pkg::VtxW-1:0] col_i;
  logic                       connected_i;
  logic [dfsam_pkg::VtxW-1:0] start_vertex_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [dfsam_pkg::VtxW-1:0] vertex_o;
  logic                       last_o;
  logic                       error_o;

  // Set by the stimulus: calm turns idling off on both sides, and the hold
  // request makes the receiver stall for a long stretch.
  bit calm;
  bit long_hold_req;

  // One visit as it leaves the block.
  typedef struct packed {
    logic [dfsam_pkg::VtxW-1:0] vertex;
    logic                       last;
    logic                       error;
  } visit_t;

  // Keeps a copy of the graph and the vertex count, works out the visit order
  // of every accepted search and checks the visits that come out.
  class dfs_visit_board;
    logic [dfsam_pkg::MaxVertices-1:0] adj [dfsam_pkg::MaxVertices];
    logic [dfsam_pkg::VcW-1:0]         vcount;
    visit_t                            pending_visits [$];
    int unsigned                       faults;

    function new();
      foreach (adj[i]) adj[i] = '0;
      vcount = dfsam_pkg::VertexCountReset;
      faults = 0;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void note_vertex_count(logic [dfsam_pkg::VcW-1:0] value);
      vcount = value;
    endfunction

    // Edge writes update both mirror bits; searches run the depth-first walk.
    function void note_item(logic m, logic [dfsam_pkg::VtxW-1:0] r,
                            logic [dfsam_pkg::VtxW-1:0] c,
                            logic conn, logic [dfsam_pkg::VtxW-1:0] s);
      logic [dfsam_pkg::VtxW-1:0]        stk [dfsam_pkg::StackDepth];
      logic [dfsam_pkg::MaxVertices-1:0] seen;
      logic [dfsam_pkg::VtxW-1:0]        v;
      int unsigned                       sp;
      int unsigned                       n;
      int unsigned                       count;
      visit_t                            rec;
      visit_t                            found [$];
      if (m == dfsam_pkg::ModeEdge) begin
        adj[r][c] = conn;
        adj[c][r] = conn;
        return;
      end
      n = (vcount > dfsam_pkg::MaxVertices) ? dfsam_pkg::MaxVertices : vcount;
      if (s >= n) begin
        rec.vertex = '0;
        rec.last   = 1'b1;
        rec.error  = 1'b1;
        pending_visits.push_back(rec);
        return;
      end
      seen   = '0;
      count  = 0;
      stk[0] = s;
      sp     = 1;
      while (sp > 0) begin
        sp--;
        v = stk[sp];
        if (seen[v]) continue;
        if (count >= dfsam_pkg::MaxResults) break;
        seen[v]    = 1'b1;
        rec.vertex = v;
        rec.last   = 1'b0;
        rec.error  = 1'b0;
        found.push_back(rec);
        count++;
        // Unvisited neighbors go on the stack in ascending order.
        for (int unsigned i = 0; i < n; i++) begin
          if (adj[v][i] && !seen[i] && sp < dfsam_pkg::StackDepth) begin
            stk[sp] = dfsam_pkg::VtxW'(i);
            sp++;
          end
        end
      end
      found[found.size()-1].last = 1'b1;
      foreach (found[i]) pending_visits.push_back(found[i]);
    endfunction

    function void check_visit(visit_t got);
      visit_t want;
      if (pending_visits.size() == 0) begin
        fault($sformatf("unexpected visit: vertex %0d last %0b error %0b",
                        got.vertex, got.last, got.error));
        return;
      end
      want = pending_visits.pop_front();
      if (got.vertex !== want.vertex || got.last !== want.last ||
          got.error !== want.error) begin
        fault({$sformatf("visit mismatch: expected vertex %0d last %0b error %0b, ",
                         want.vertex, want.last, want.error),
               $sformatf("got vertex %0d last %0b error %0b",
                         got.vertex, got.last, got.error)});
      end
    endfunction
  endclass

  dfs_visit_board board;

  depth_first_search_adjacency_matrix_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .row_i              (row_i),
    .col_i              (col_i),
    .connected_i        (connected_i),
    .start_vertex_i     (start_vertex_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .vertex_o           (vertex_o),
    .last_o             (last_o),
    .error_o            (error_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one graph transaction and waits until the block takes it.
  // Called just after a rising edge; valid only drops during an idle gap.
  task automatic send_item(input logic m, input logic [dfsam_pkg::VtxW-1:0] r,
                           input logic [dfsam_pkg::VtxW-1:0] c, input logic conn,
                           input logic [dfsam_pkg::VtxW-1:0] s);
    logic rdy;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    row_i          <= r;
    col_i          <= c;
    connected_i    <= conn;
    start_vertex_i <= s;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    board.note_item(m, r, c, conn, s);
  endtask

  // Mostly edges and searches among the vertices in use, some pure noise.
  task automatic send_random_item();
    int unsigned                n;
    int unsigned                pick;
    logic                       m;
    logic                       conn;
    logic [dfsam_pkg::VtxW-1:0] r;
    logic [dfsam_pkg::VtxW-1:0] c;
    logic [dfsam_pkg::VtxW-1:0] s;
    n    = (board.vcount > dfsam_pkg::MaxVertices) ? dfsam_pkg::MaxVertices : board.vcount;
    pick = $urandom_range(99);
    r    = dfsam_pkg::VtxW'($urandom);
    c    = dfsam_pkg::VtxW'($urandom);
    s    = dfsam_pkg::VtxW'($urandom);
    conn = 1'($urandom);
    if (pick < 90 && n > 0) begin
      r    = dfsam_pkg::VtxW'($urandom_range(n - 1));
      c    = dfsam_pkg::VtxW'($urandom_range(n - 1));
      s    = dfsam_pkg::VtxW'($urandom_range(n - 1));
      conn = ($urandom_range(99) < 65);
    end
    if (pick < 30) m = dfsam_pkg::ModeSearch;
    else if (pick < 90) m = dfsam_pkg::ModeEdge;
    else m = 1'($urandom);
    send_item(m, r, c, conn, s);
  endtask

  // Writes the vertex count register; only called while the block is idle.
  task automatic write_vertex_count(input logic [dfsam_pkg::VcW-1:0] value);
    logic rdy;
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    board.note_vertex_count(value);
  endtask

  // Stops offering, waits for every outstanding visit, then lets the block settle.
  task automatic wait_for_visits_done();
    in_valid_i <= 1'b0;
    while (board.pending_visits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold on request, checks at the falling edge.
  initial begin : sink
    int unsigned hold_left;
    visit_t      got;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        hold_left     = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 16);
      end
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.vertex = vertex_o;
        got.last   = last_o;
        got.error  = error_o;
        board.check_visit(got);
      end
    end
  end

  // Stimulus: directed cases, then random phases under several vertex counts.
  initial begin : stimulus
    logic [dfsam_pkg::VcW-1:0] vc_plan [7];
    int unsigned               waited;
    visit_t                    left;
    board              = new();
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_vertex_count_i = '0;
    in_valid_i         = 1'b0;
    mode_i             = dfsam_pkg::ModeEdge;
    row_i              = '0;
    col_i              = '0;
    connected_i        = 1'b0;
    start_vertex_i     = '0;
    calm               = 1'b0;
    long_hold_req      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty graph at the reset vertex count, lowest and highest start vertex.
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd0);
    send_item(dfsam_pkg::ModeSearch, 4'd15, 4'd15, 1'b1, 4'd15);
    // A small graph with a self loop, the top vertex, and a cleared mirror edge.
    send_item(dfsam_pkg::ModeEdge, 4'd0, 4'd1, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd1, 4'd2, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd0, 4'd3, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd5, 4'd5, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd15, 4'd14, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd2, 4'd15, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd6, 4'd7, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd7, 4'd6, 1'b0, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd10, 4'd9, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeEdge, 4'd9, 4'd12, 1'b1, 4'd0);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd0);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd5);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd6);

    // Four vertices: starts beyond the count fail, edges beyond it are not followed.
    wait_for_visits_done();
    write_vertex_count(dfsam_pkg::VcW'(4));
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd4);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd15);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd0);

    // A count of zero fails every search.
    wait_for_visits_done();
    write_vertex_count(dfsam_pkg::VcW'(0));
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd0);

    // A count above the matrix size acts as the full matrix.
    wait_for_visits_done();
    write_vertex_count(dfsam_pkg::VcW'(31));
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd15);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd10);

    // A single vertex.
    wait_for_visits_done();
    write_vertex_count(dfsam_pkg::VcW'(1));
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd0);
    send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd1);

    // Random phases; the first one opens with a long receiver hold, the third
    // runs without any idling.
    vc_plan[0] = dfsam_pkg::VcW'(31);
    vc_plan[1] = dfsam_pkg::VcW'(16);
    vc_plan[2] = dfsam_pkg::VcW'(8);
    vc_plan[3] = dfsam_pkg::VcW'($urandom_range(15, 2));
    vc_plan[4] = dfsam_pkg::VcW'(1);
    vc_plan[5] = dfsam_pkg::VcW'(0);
    vc_plan[6] = dfsam_pkg::VcW'(16);
    for (int p = 0; p < 7; p++) begin
      wait_for_visits_done();
      write_vertex_count(vc_plan[p]);
      calm = (p == 2);
      if (p == 0) begin
        long_hold_req = 1'b1;
        send_item(dfsam_pkg::ModeSearch, 4'd0, 4'd0, 1'b0, 4'd0);
      end
      for (int k = 0; k < PhaseItems; k++) send_random_item();
    end
    calm = 1'b0;

    // Drain with a limit; anything still expected afterwards is a failure.
    in_valid_i <= 1'b0;
    waited = 0;
    while (board.pending_visits.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    while (board.pending_visits.size() != 0) begin
      left = board.pending_visits.pop_front();
      board.fault($sformatf("missing visit: vertex %0d last %0b error %0b",
                            left.vertex, left.last, left.error));
    end
    if (board.faults == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin : watchdog
    #10000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
